/* sv/olpi_pkg.sv */
// Shared types and constants for the ordered list with positional insert.
package olpi_pkg;

    // Widths of the transfer fields.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;

    // Cell indexes are carried at a fixed width that covers the largest list.
    localparam int unsigned IDX_W    = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_DEL_FIRST = 2'd1,
        OP_DEL_LAST  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Command broadcast from the controller to every cell in the row.
    typedef struct packed {
        logic              ins;        // insert takes effect this cycle
        logic              del_front;  // delete-first takes effect this cycle
        logic [IDX_W-1:0]  ins_idx;    // zero-based insert slot
        logic [IDX_W-1:0]  tap_idx;    // cell whose byte is read out
        logic [DATA_W-1:0] value;      // byte to insert
    } t_cell_cmd;

endpackage

/* sv/olpi_cell.sv */
// One storage cell of the list: holds a byte and shifts with its neighbors.
module olpi_cell
    import olpi_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] K = IDX_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            // Cells past the insert slot take their lower neighbor's byte.
            if (K > i_cmd.ins_idx) begin
                n_data = i_left;
            end else if (K == i_cmd.ins_idx) begin
                n_data = i_cmd.value;
            end
        end else if (i_cmd.del_front) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the addressed cell drives its tap; the controller ORs all taps.
    assign o_tap  = (K == i_cmd.tap_idx) ? r_data : '0;

endmodule

/* sv/ordered_list_positional_insert.sv */
// Ordered byte list with positional insert, delete-first and delete-last.
// A result is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; every cell shifts or holds at the transfer.
// The input is taken while the output register is empty or being drained.
// Reset clears the element count and the output valid; cell bytes keep
// whatever they hold and are only read below the count.
module ordered_list_positional_insert
    import olpi_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // op[1:0], position[6:2], value[14:7], zero[15]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // removed_value[7:0], count[12:8], status[14:13], zero[15]
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_valid;
    logic [DATA_W-1:0]   r_removed;
    logic [CNT_W-1:0]    r_count_out;
    t_status             r_status;

    t_op                 w_op;
    logic [POS_W-1:0]    w_pos;
    logic [DATA_W-1:0]   w_value;
    logic                w_take;
    logic                w_full;
    logic                w_empty;
    logic                w_pos_bad;
    t_status             w_status;
    t_cell_cmd           w_cmd;
    logic [DATA_W-1:0]   w_tap_or;
    logic [DATA_W-1:0]   w_removed;

    logic [DATA_W-1:0]   w_data [CAPACITY];
    logic [DATA_W-1:0]   w_tap  [CAPACITY];

    assign w_op    = t_op'(i_s_axis_tdata[1:0]);
    assign w_pos   = i_s_axis_tdata[6:2];
    assign w_value = i_s_axis_tdata[14:7];

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_bad = (w_pos == '0) ||
                       (CMP_W'(w_pos) > (CMP_W'(r_count) + CMP_W'(1)));

    always_comb begin
        unique case (w_op)
            OP_INSERT: begin
                // A full list is reported before a bad position.
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_bad) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_status = ST_OK;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
                w_status = w_empty ? ST_EMPTY : ST_OK;
            end
            default: begin
                w_status = ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        w_cmd.ins       = w_take && (w_op == OP_INSERT) && (w_status == ST_OK);
        w_cmd.del_front = w_take && (w_op == OP_DEL_FIRST) && (w_status == ST_OK);
        w_cmd.ins_idx   = IDX_W'(w_pos - POS_W'(1));
        w_cmd.tap_idx   = (w_op == OP_DEL_LAST) ? IDX_W'(r_count - CNT_W'(1)) : '0;
        w_cmd.value     = w_value;
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_left
            assign w_left = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_mid_right
            assign w_right = w_data[k+1];
        end

        olpi_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    assign w_removed = (w_status == ST_OK && w_op != OP_INSERT) ? w_tap_or : '0;

    always_comb begin
        n_count = r_count;
        if (w_take && w_status == ST_OK) begin
            if (w_op == OP_INSERT) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_removed   <= w_removed;
            r_count_out <= n_count;
            r_status    <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {1'b0, r_status, COUNT_W'(r_count_out), r_removed};

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // A successful insert grows the list by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_op == OP_INSERT && w_status == ST_OK
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    // A refused operation leaves the count alone.
    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_status != ST_OK |=> $stable(r_count))
        else $error("refused operation changed the count");

    // Every accepted item produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_m_axis_tvalid)
        else $error("no result after an input transfer");

    // The reported count matches the stored count after each transfer.
    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_count_out == r_count)
        else $error("reported count differs from stored count");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the ordered byte list with positional insert.
`timescale 1ns / 1ps

module tb_top;
    import olpi_pkg::*;

    localparam int unsigned CAPACITY = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned PRESSURE_AT = 600;
    localparam int unsigned PRESSURE_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_list_cmd;

    typedef struct {
        logic [DATA_W-1:0]   removed_value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // op[1:0], position[6:2], value[14:7], zero[15]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // removed_value[7:0], count[12:8], status[14:13], zero[15]

    ordered_list_positional_insert #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];

    // Predictor state: list contents with the front at index zero.
    logic [DATA_W-1:0] list_bytes[CAPACITY];
    int unsigned       list_len = 0;

    int unsigned gen_len = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned inserts_done = 0;
    int unsigned deletes_done = 0;
    int unsigned refusals = 0;
    int unsigned peak_len = 0;

    function automatic t_list_result apply_list_op(t_list_cmd cmd);
        t_list_result res;
        res.removed_value = '0;
        res.status = ST_OK;
        if (cmd.op == OP_INSERT) begin
            if (list_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else if (cmd.position == 0 || cmd.position > list_len + 1) begin
                res.status = ST_BADPOS;
            end else begin
                for (int i = list_len; i > cmd.position - 1; i--)
                    list_bytes[i] = list_bytes[i-1];
                list_bytes[cmd.position-1] = cmd.value;
                list_len++;
            end
        end else if (cmd.op == OP_DEL_FIRST || cmd.op == OP_DEL_LAST) begin
            if (list_len == 0) begin
                res.status = ST_EMPTY;
            end else if (cmd.op == OP_DEL_FIRST) begin
                res.removed_value = list_bytes[0];
                for (int i = 0; i + 1 < list_len; i++)
                    list_bytes[i] = list_bytes[i+1];
                list_len--;
            end else begin
                res.removed_value = list_bytes[list_len-1];
                list_len--;
            end
        end else begin
            res.status = ST_BADPOS;
        end
        res.count = list_len[COUNT_W-1:0];
        if (res.status != ST_OK)
            refusals++;
        else if (cmd.op == OP_INSERT)
            inserts_done++;
        else
            deletes_done++;
        if (list_len > peak_len)
            peak_len = list_len;
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned draw_gap(bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [DATA_W-1:0] val);
        t_list_cmd cmd;
        cmd.op = op;
        cmd.position = pos;
        cmd.value = val;
        pending_cmds.push_back(cmd);
        // Track only the length so that random positions can aim at valid slots.
        if (op == OP_INSERT) begin
            if (gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1)
                gen_len++;
        end else if (op != OP_UNUSED && gen_len > 0) begin
            gen_len--;
        end
    endtask

    task automatic build_stimulus();
        int unsigned mode;
        int unsigned insert_pct;
        int unsigned r;
        logic [POS_W-1:0] pos;
        // Refusals on an empty list, including the unused op code.
        queue_cmd(OP_DEL_FIRST, 5'd0, 8'h00);
        queue_cmd(OP_DEL_LAST, 5'd31, 8'hFF);
        queue_cmd(OP_INSERT, 5'd0, 8'h11);
        queue_cmd(OP_INSERT, 5'd2, 8'h22);
        queue_cmd(OP_INSERT, 5'd31, 8'hFF);
        queue_cmd(OP_UNUSED, 5'd1, 8'h33);
        // Insert at the front, at the back and in the middle.
        queue_cmd(OP_INSERT, 5'd1, 8'hFF);
        queue_cmd(OP_INSERT, 5'd1, 8'h00);
        queue_cmd(OP_INSERT, 5'd3, 8'hA5);
        queue_cmd(OP_INSERT, 5'd2, 8'h5A);
        // Fill up to capacity, then try once more on the full list.
        for (int i = 5; i <= CAPACITY; i++)
            queue_cmd(OP_INSERT, POS_W'(i), DATA_W'(i * 17));
        queue_cmd(OP_INSERT, 5'd1, 8'h77);
        queue_cmd(OP_DEL_FIRST, 5'd0, 8'h00);
        queue_cmd(OP_DEL_LAST, 5'd0, 8'h00);

        mode = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Work in phases that lean toward filling, draining or balance.
            if (n % 40 == 0)
                mode = $urandom_range(2);
            insert_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            r = $urandom_range(99);
            if (r < 2) begin
                queue_cmd(OP_UNUSED, POS_W'($urandom_range(31)), DATA_W'($urandom_range(255)));
            end else if (r < insert_pct) begin
                if ($urandom_range(9) == 0)
                    pos = $urandom_range(1) ? '0 : POS_W'($urandom_range(31, gen_len + 2));
                else
                    pos = POS_W'($urandom_range(gen_len + 1, 1));
                queue_cmd(OP_INSERT, pos, DATA_W'($urandom_range(255)));
            end else begin
                queue_cmd($urandom_range(1) ? OP_DEL_FIRST : OP_DEL_LAST,
                          POS_W'($urandom_range(31)), DATA_W'($urandom_range(255)));
            end
        end
    endtask

    // Sender side.
    t_list_cmd    next_cmd;
    t_list_cmd    sent_cmd;
    int unsigned  send_gap = 0;
    bit           tx_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent_cmd.op       = s_tdata[1:0];
                sent_cmd.position = s_tdata[6:2];
                sent_cmd.value    = s_tdata[14:7];
                expected_results.push_back(apply_list_op(sent_cmd));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    next_cmd = pending_cmds.pop_front();
                    s_tdata  <= {1'b0, next_cmd.value, next_cmd.position, next_cmd.op};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(99) == 0)
                        tx_calm = ~tx_calm;
                    send_gap <= draw_gap(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: checks every result transfer against the oldest prediction.
    t_list_result want;
    int unsigned  recv_wait = 0;
    bit           rx_calm = 1'b0;
    bit           pressure_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("Result transfer with no prediction pending: data %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[12:8] !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_tdata[12:8]);
                        mismatch_count++;
                    end
                    if (m_tdata[14:13] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[14:13]);
                        mismatch_count++;
                    end
                end
            end
            if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_tready  <= 1'b0;
            end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
                // One long hold-off so that the block backs up and stalls its input.
                pressure_done <= 1'b1;
                recv_wait     <= PRESSURE_CYCLES;
                m_tready      <= 1'b0;
            end else begin
                if ($urandom_range(99) == 0)
                    rx_calm = ~rx_calm;
                m_tready  <= 1'b1;
                recv_wait <= draw_gap(rx_calm);
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Sample between edges so that the driver and monitor have settled.
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d result transfers: %0d inserts, %0d deletes, %0d refusals.",
                 results_seen, inserts_done, deletes_done, refusals);
        $display("The list held at most %0d entries; one long receiver hold-off applied.",
                 peak_len);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timeout with %0d predictions outstanding.", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
